@@ src/cld_pkg.sv @@
package cld_pkg;

    // Item types
    typedef struct packed {
        logic [7:0] luma;
        logic       last_in_line;
    } sample_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_line;
    } pixel_t;

    // Register file widths and indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 54;
    localparam int TRIG_W     = 16;
    localparam int COEF_W     = 18;

    localparam logic [CFG_IDX_W-1:0] REG_BURST_SINE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_COSINE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_ROW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_ROW     = 3'd4;

    typedef struct packed {
        logic signed [TRIG_W-1:0] burst_sine;
        logic signed [TRIG_W-1:0] burst_cosine;
        logic [CFG_DATA_W-1:0]    red_row;
        logic [CFG_DATA_W-1:0]    green_row;
        logic [CFG_DATA_W-1:0]    blue_row;
    } cfg_t;

    localparam logic signed [TRIG_W-1:0] BURST_SINE_RST   = 16'sd17846;
    localparam logic signed [TRIG_W-1:0] BURST_COSINE_RST = 16'sd27482;
    localparam logic [CFG_DATA_W-1:0]    RED_ROW_RST      = 54'd16384;
    localparam logic [CFG_DATA_W-1:0]    GREEN_ROW_RST    = 54'd16384 << 18;
    localparam logic [CFG_DATA_W-1:0]    BLUE_ROW_RST     = 54'd16384 << 36;

    // Datapath widths
    localparam int TAP_W  = 16;
    localparam int DIST_W = 4;   // tap distance 0..8
    localparam int A_W    = 27;  // sum of luma * tap
    localparam int KC_W   = 34;  // matrix coefficient * trig
    localparam int PROD_W = 61;
    localparam int SUM_W  = 62;
    localparam int FRAC_SHIFT = 44;

    // Back-end skid queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Channel codes
    localparam logic [1:0] CH_Y = 2'd0;
    localparam logic [1:0] CH_I = 2'd1;
    localparam logic [1:0] CH_Q = 2'd2;

    // Q1.15 low-pass taps by distance from centre
    function automatic logic signed [TAP_W-1:0] tap_value(
        input logic [DIST_W-1:0] tap_dist,
        input logic [1:0]        ch
    );
        logic signed [TAP_W-1:0] y, i, q;
        begin
            case (tap_dist)
                4'd0:    begin y = 16'sd9156; i = 16'sd12261; q = 16'sd8529; end
                4'd1:    begin y = 16'sd7731; i = 16'sd11182; q = 16'sd8122; end
                4'd2:    begin y = 16'sd4411; i = 16'sd8404;  q = 16'sd7003; end
                4'd3:    begin y = 16'sd1201; i = 16'sd5031;  q = 16'sd5440; end
                4'd4:    begin y = -16'sd504; i = 16'sd2182;  q = 16'sd3771; end
                4'd5:    begin y = -16'sd724; i = 16'sd449;   q = 16'sd2296; end
                4'd6:    begin y = -16'sd327; i = -16'sd220;  q = 16'sd1195; end
                4'd7:    begin y = -16'sd24;  i = -16'sd262;  q = 16'sd506;  end
                4'd8:    begin y = 16'sd42;   i = -16'sd129;  q = 16'sd169;  end
                default: begin y = '0;        i = '0;         q = '0;        end
            endcase
            case (ch)
                CH_Y:    tap_value = y;
                CH_I:    tap_value = i;
                CH_Q:    tap_value = q;
                default: tap_value = '0;
            endcase
        end
    endfunction

endpackage

@@ src/composite_luma_to_rgb_decoder_unit.sv @@
// Composite-to-RGB scanline decoder. One 8-bit composite sample goes in per
// item with a line-end mark; each sample is demodulated against a quarter-rate
// subcarrier (burst angle plus 90 degrees per pixel) into Y, I and Q, passed
// through a symmetric (2*TAPS_PER_SIDE+1)-tap low-pass filter per channel with
// zeros beyond the line edges, run through the 3x3 decode matrix and clamped
// to 0..255. A pixel comes out TAPS_PER_SIDE samples after it arrives; at line
// end the front flushes the pending pixels, holding off input while it does
// so and while the job queue is full, and a line also ends at sample
// MAX_LINE_LENGTH-1.
// For each pixel the back end makes one pass over the window, then fifteen
// turns of the single 34x27 multiply-accumulate for the matrix, then the clamp,
// and pops no new job until the pixel is loaded for output. The front accepts
// a sample per cycle while no flush runs and the four-entry job queue has room.
// Registers: 0 burst sine, 1 burst cosine (signed Q1.15), 2..4 red, green and
// blue rows, each three signed Q4.14 coefficients for Y (bits 17:0),
// I (35:18) and Q (53:36). Write them only while the block is idle.
module composite_luma_to_rgb_decoder_unit #(
    parameter int TAPS_PER_SIDE   = 5,
    parameter int MAX_LINE_LENGTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [cld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  cld_pkg::sample_t                  sample,
    output logic                              pixel_valid,
    input  logic                              pixel_stall,
    output cld_pkg::pixel_t                   pixel
);

    // one job: window of samples, low bits of the centre position, last mark
    localparam int JOB_W = (2 * TAPS_PER_SIDE + 1) * 8 + 3;

    cld_pkg::cfg_t cfg_reg;

    logic             q_push, q_full, q_pop, q_empty;
    logic [JOB_W-1:0] q_push_data, q_pop_data;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burst_sine   <= cld_pkg::BURST_SINE_RST;
            cfg_reg.burst_cosine <= cld_pkg::BURST_COSINE_RST;
            cfg_reg.red_row      <= cld_pkg::RED_ROW_RST;
            cfg_reg.green_row    <= cld_pkg::GREEN_ROW_RST;
            cfg_reg.blue_row     <= cld_pkg::BLUE_ROW_RST;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                cld_pkg::REG_BURST_SINE:   cfg_reg.burst_sine   <= signed'(cfg_data[15:0]);
                cld_pkg::REG_BURST_COSINE: cfg_reg.burst_cosine <= signed'(cfg_data[15:0]);
                cld_pkg::REG_RED_ROW:      cfg_reg.red_row      <= cfg_data;
                cld_pkg::REG_GREEN_ROW:    cfg_reg.green_row    <= cfg_data;
                cld_pkg::REG_BLUE_ROW:     cfg_reg.blue_row     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // front: windowing, line bookkeeping and flush
    cld_front #(
        .TAPS_PER_SIDE   (TAPS_PER_SIDE),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (q_push),
        .push_data    (q_push_data),
        .full         (q_full)
    );

    cld_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // back: filter, matrix, clamp, output register
    cld_back #(
        .TAPS_PER_SIDE (TAPS_PER_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_ready   (~q_empty),
        .job_pop     (q_pop),
        .job         (q_pop_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> sample_stall)
        else $error("sample taken while queue full");
`endif

endmodule

@@ src/cld_queue.sv @@
module cld_queue #(
    parameter int WIDTH = 91
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0]              slot_reg [cld_pkg::QUEUE_DEPTH];
    logic [cld_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [cld_pkg::QPTR_W:0]      count_reg, count_next;

    assign full     = (count_reg == (cld_pkg::QPTR_W+1)'(cld_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/cld_front.sv @@
module cld_front #(
    parameter int TAPS_PER_SIDE   = 5,
    parameter int MAX_LINE_LENGTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  cld_pkg::sample_t              sample,
    output logic                          push,
    output logic [(2*TAPS_PER_SIDE+1)*8+2:0] push_data,
    input  logic                          full
);

    localparam int WIN   = 2 * TAPS_PER_SIDE + 1;
    localparam int WIN_W = WIN * 8;
    localparam int CNT_W = $clog2(MAX_LINE_LENGTH);
    localparam int FW    = $clog2(TAPS_PER_SIDE + 1);

    logic [WIN_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [FW-1:0]    fcnt_reg, fcnt_next;
    logic             flush_reg, flush_next;

    logic             accept, last;
    logic [WIN_W-1:0] shifted;
    logic [1:0]       cpos;

    assign sample_stall = flush_reg | full;
    assign accept       = sample_valid & ~sample_stall;

    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        s_next     = s_reg;
        fcnt_next  = fcnt_reg;
        flush_next = flush_reg;
        push       = 1'b0;
        push_data  = '0;
        last       = 1'b0;
        shifted    = '0;
        cpos       = '0;
        if (accept)
        begin
            // newest sample at entry 0
            shifted = {win_reg[WIN_W-9:0], sample.luma};
            last    = sample.last_in_line
                      || (count_reg >= CNT_W'(MAX_LINE_LENGTH - 1));
            cpos    = 2'(count_reg - CNT_W'(TAPS_PER_SIDE));
            win_next = shifted;
            if (count_reg >= CNT_W'(TAPS_PER_SIDE))
            begin
                push      = 1'b1;
                push_data = {1'b0, cpos, shifted};
            end
            if (last)
            begin
                flush_next = 1'b1;
                s_next     = count_reg;
                fcnt_next  = FW'(1);
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (flush_reg && !full)
        begin
            shifted = {win_reg[WIN_W-9:0], 8'h00};
            cpos    = s_reg[1:0] - 2'(TAPS_PER_SIDE) + 2'(fcnt_reg);
            if (({1'b0, s_reg} + (CNT_W+1)'(fcnt_reg)) >= (CNT_W+1)'(TAPS_PER_SIDE))
            begin
                push      = 1'b1;
                push_data = {(fcnt_reg == FW'(TAPS_PER_SIDE)), cpos, shifted};
            end
            if (fcnt_reg == FW'(TAPS_PER_SIDE))
            begin
                win_next   = '0;
                flush_next = 1'b0;
            end
            else
            begin
                win_next  = shifted;
                fcnt_next = fcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
            s_reg     <= '0;
            fcnt_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
            s_reg     <= s_next;
            fcnt_reg  <= fcnt_next;
            flush_reg <= flush_next;
        end
    end

endmodule

@@ src/cld_back.sv @@
module cld_back #(
    parameter int TAPS_PER_SIDE = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cld_pkg::cfg_t                 cfg,
    input  logic                          job_ready,
    output logic                          job_pop,
    input  logic [(2*TAPS_PER_SIDE+1)*8+2:0] job,
    output logic                          pixel_valid,
    input  logic                          pixel_stall,
    output cld_pkg::pixel_t               pixel
);

    localparam int WIN   = 2 * TAPS_PER_SIDE + 1;
    localparam int WIN_W = WIN * 8;
    localparam int KW    = $clog2(WIN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAP   = 3'd1;
    localparam logic [2:0] ST_MAT   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] TERM_LAST = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [7:0]  win_reg [WIN];
    logic [1:0]  cpos_reg;
    logic        last_reg;
    logic [KW-1:0] k_reg;

    logic signed [cld_pkg::A_W-1:0] ay_reg, ais_reg, aic_reg, aqs_reg, aqc_reg;
    logic signed [cld_pkg::KC_W-1:0] kc_reg [3][5];
    logic signed [cld_pkg::KC_W-1:0] kc_next [3][5];
    logic [1:0]  ch_reg;
    logic [2:0]  term_reg;
    logic signed [cld_pkg::PROD_W-1:0] prod_reg;
    logic [1:0]  prod_ch_reg;
    logic        prod_valid_reg;
    logic signed [cld_pkg::SUM_W-1:0] acc_reg [3];

    logic              out_valid_reg;
    cld_pkg::pixel_t   out_reg;

    // tap step
    logic [cld_pkg::DIST_W-1:0] tap_dist;
    logic [1:0]                 ph;
    logic [7:0]                 lum;
    logic signed [24:0]         py, pi, pq;
    logic signed [cld_pkg::A_W-1:0] ey, ei, eq;

    // matrix step
    logic signed [cld_pkg::KC_W-1:0] kc_sel;
    logic signed [cld_pkg::A_W-1:0]  a_sel;
    logic signed [cld_pkg::PROD_W-1:0] prod_next;

    logic out_load, out_take;

    function automatic logic [7:0] clamp_out(input logic signed [cld_pkg::SUM_W-1:0] v);
        logic signed [cld_pkg::SUM_W-1:0] r;
        begin
            r = v >>> cld_pkg::FRAC_SHIFT;
            if (v < 0)
                clamp_out = 8'd0;
            else if (r > 255)
                clamp_out = 8'd255;
            else
                clamp_out = r[7:0];
        end
    endfunction

    // coefficient products, follow the registers
    always_comb
    begin
        logic [cld_pkg::CFG_DATA_W-1:0] row;
        logic signed [cld_pkg::COEF_W-1:0] ry, ri, rq;
        for (int c = 0; c < 3; c++)
        begin
            row = (c == 0) ? cfg.red_row : ((c == 1) ? cfg.green_row : cfg.blue_row);
            ry  = signed'(row[17:0]);
            ri  = signed'(row[35:18]);
            rq  = signed'(row[53:36]);
            kc_next[c][0] = {ry[17], ry, 15'b0};
            kc_next[c][1] = ri * cfg.burst_sine;
            kc_next[c][2] = ri * cfg.burst_cosine;
            kc_next[c][3] = rq * cfg.burst_cosine;
            kc_next[c][4] = rq * cfg.burst_sine;
        end
    end

    always_ff @(posedge clk)
    begin
        kc_reg <= kc_next;
    end

    // tap step datapath
    always_comb
    begin
        if (k_reg <= KW'(TAPS_PER_SIDE))
            tap_dist = cld_pkg::DIST_W'(KW'(TAPS_PER_SIDE) - k_reg);
        else
            tap_dist = cld_pkg::DIST_W'(k_reg - KW'(TAPS_PER_SIDE));
        ph  = cpos_reg + 2'(TAPS_PER_SIDE) - k_reg[1:0];
        lum = win_reg[k_reg];
        py  = $signed({1'b0, lum}) * cld_pkg::tap_value(tap_dist, cld_pkg::CH_Y);
        pi  = $signed({1'b0, lum}) * cld_pkg::tap_value(tap_dist, cld_pkg::CH_I);
        pq  = $signed({1'b0, lum}) * cld_pkg::tap_value(tap_dist, cld_pkg::CH_Q);
        ey  = cld_pkg::A_W'(py);
        ei  = cld_pkg::A_W'(pi);
        eq  = cld_pkg::A_W'(pq);
    end

    // matrix step operands
    always_comb
    begin
        kc_sel = kc_reg[ch_reg][term_reg];
        case (term_reg)
            3'd0:    a_sel = ay_reg;
            3'd1:    a_sel = ais_reg;
            3'd2:    a_sel = aic_reg;
            3'd3:    a_sel = aqc_reg;
            3'd4:    a_sel = aqs_reg;
            default: a_sel = '0;
        endcase
        prod_next = kc_sel * a_sel;
    end

    assign out_take = out_valid_reg & ~pixel_stall;
    assign out_load = (state_reg == ST_OUT) & (~out_valid_reg | ~pixel_stall);
    assign job_pop  = (state_reg == ST_IDLE) & job_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_ready)
                    state_next = ST_TAP;
            end
            ST_TAP:
            begin
                if (k_reg == KW'(WIN - 1))
                    state_next = ST_MAT;
            end
            ST_MAT:
            begin
                if (ch_reg == cld_pkg::CH_Q && term_reg == TERM_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prod_valid_reg <= (state_reg == ST_MAT);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            for (int i = 0; i < WIN; i++)
                win_reg[i] <= job[i*8 +: 8];
            cpos_reg <= job[WIN_W +: 2];
            last_reg <= job[WIN_W + 2];
            k_reg    <= '0;
            ch_reg   <= cld_pkg::CH_Y;
            term_reg <= '0;
            ay_reg   <= '0;
            ais_reg  <= '0;
            aic_reg  <= '0;
            aqs_reg  <= '0;
            aqc_reg  <= '0;
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= '0;
        end
        if (state_reg == ST_TAP)
        begin
            k_reg  <= k_reg + 1'b1;
            ay_reg <= ay_reg + ey;
            // subcarrier phase picks sine or cosine and its sign
            case (ph)
                2'd0:    begin ais_reg <= ais_reg + ei; aqc_reg <= aqc_reg + eq; end
                2'd1:    begin aic_reg <= aic_reg + ei; aqs_reg <= aqs_reg - eq; end
                2'd2:    begin ais_reg <= ais_reg - ei; aqc_reg <= aqc_reg - eq; end
                default: begin aic_reg <= aic_reg - ei; aqs_reg <= aqs_reg + eq; end
            endcase
        end
        if (state_reg == ST_MAT)
        begin
            prod_reg    <= prod_next;
            prod_ch_reg <= ch_reg;
            if (term_reg == TERM_LAST)
            begin
                term_reg <= '0;
                ch_reg   <= ch_reg + 1'b1;
            end
            else
            begin
                term_reg <= term_reg + 1'b1;
            end
        end
        if (prod_valid_reg)
            acc_reg[prod_ch_reg] <= acc_reg[prod_ch_reg] + cld_pkg::SUM_W'(prod_reg);
        if (out_load)
        begin
            out_reg.red          <= clamp_out(acc_reg[0]);
            out_reg.green        <= clamp_out(acc_reg[1]);
            out_reg.blue         <= clamp_out(acc_reg[2]);
            out_reg.last_of_line <= last_reg;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule
